@@ rtl/rrqs_pkg.sv @@
`default_nettype none

package rrqs_pkg;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_QUANTUM = 1'b0,
      REG_NONE    = 1'b1
   } reg_index_type;

   localparam logic [7:0] QUANTUM_RESET = 8'd3;

   typedef struct packed {
      logic       shift;
      logic       load;
      logic [7:0] id;
      logic [7:0] burst;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/round_robin_quantum_scheduler.sv @@
`default_nettype none
// Round-robin time-slice scheduler.
// Request channel (req_valid / req_stall): one beat is either an add
// (process id and burst appended at the tail of the ready queue) or a
// timer tick (the head process runs for one tick).
// Response channel (rsp_valid / rsp_stall): exactly one beat per request,
// giving the process that ran, its remaining burst, finish / rotate / idle
// / reject flags and the queue occupancy after the request.
// The response is registered: rsp_valid is set in the cycle after a request
// is accepted. Throughput is one request per cycle while no response is
// stalled: the queue is a row of cells that shift towards the head, and
// every request is one update of the row, occupancy and quantum counters.
// A stalled response holds in the output register; a new request is taken
// in the cycle the held response is taken, otherwise req_stall is raised.
// Reset empties the queue, sets the quantum register to 3 and drops any
// pending response. The quantum register is written over the APB port and
// takes effect at the next change of the head process.
module round_robin_quantum_scheduler #(
   parameter int MAX_PROCS = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_command,
   input  wire  [7:0]  req_process_id,
   input  wire  [7:0]  req_burst,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_ran_valid,
   output logic [7:0]  rsp_ran_id,
   output logic [7:0]  rsp_ran_remaining,
   output logic        rsp_finished,
   output logic        rsp_rotated,
   output logic        rsp_idle,
   output logic        rsp_add_rejected,
   output logic [3:0]  rsp_queue_count,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [2:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rrqs_pkg::*;

   localparam int CW = $clog2(MAX_PROCS + 1);

   logic [7:0]    quantum;
   logic [7:0]    cell_id    [MAX_PROCS];
   logic [7:0]    cell_burst [MAX_PROCS];
   logic [7:0]    nb_id      [MAX_PROCS];
   logic [7:0]    nb_burst   [MAX_PROCS];
   logic          cell_sel   [MAX_PROCS];
   cell_ctrl_type ctrl;
   logic [CW-1:0] slot;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [7:0]    qleft_ff;
   logic [7:0]    qleft_in;
   logic          accept;
   logic [7:0]    rem;
   logic [7:0]    ql;
   logic [CW+3:0] count_ext;

   logic          ran_valid;
   logic          finished;
   logic          rotated;
   logic          idle;
   logic          add_rejected;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          ran_valid_ff;
   logic [7:0]    ran_id_ff;
   logic [7:0]    ran_remaining_ff;
   logic          finished_ff;
   logic          rotated_ff;
   logic          idle_ff;
   logic          add_rejected_ff;
   logic [3:0]    queue_count_ff;

   rrqs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .quantum (quantum)
   );

   for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
      if (i == MAX_PROCS - 1) begin : g_last
         assign nb_id[i]    = cell_id[i];
         assign nb_burst[i] = cell_burst[i];
      end else begin : g_mid
         assign nb_id[i]    = cell_id[i+1];
         assign nb_burst[i] = cell_burst[i+1];
      end
      assign cell_sel[i] = (slot == CW'(i));

      rrqs_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .sel      (cell_sel[i]),
         .nb_id    (nb_id[i]),
         .nb_burst (nb_burst[i]),
         .id       (cell_id[i]),
         .burst    (cell_burst[i])
      );
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign rem = (cell_burst[0] == 8'd0) ? 8'd0 : cell_burst[0] - 8'd1;
   assign ql  = (qleft_ff == 8'd0) ? 8'd0 : qleft_ff - 8'd1;

   always_comb begin
      ctrl         = '0;
      slot         = '0;
      count_in     = count_ff;
      qleft_in     = qleft_ff;
      ran_valid    = 1'b0;
      finished     = 1'b0;
      rotated      = 1'b0;
      idle         = 1'b0;
      add_rejected = 1'b0;
      if (accept) begin
         case (cmd_type'(req_command))
            CMD_ADD: begin
               if (count_ff == CW'(MAX_PROCS)) begin
                  add_rejected = 1'b1;
               end else begin
                  ctrl.load  = 1'b1;
                  ctrl.id    = req_process_id;
                  ctrl.burst = req_burst;
                  slot       = count_ff;
                  count_in   = count_ff + CW'(1);
                  if (count_ff == '0) begin
                     qleft_in = quantum;
                  end
               end
            end
            CMD_TICK: begin
               if (count_ff == '0) begin
                  idle = 1'b1;
               end else begin
                  ran_valid = 1'b1;
                  if (rem == 8'd0) begin
                     finished   = 1'b1;
                     ctrl.shift = 1'b1;
                     count_in   = count_ff - CW'(1);
                     qleft_in   = quantum;
                  end else if (ql == 8'd0) begin
                     rotated    = 1'b1;
                     ctrl.shift = 1'b1;
                     ctrl.load  = 1'b1;
                     ctrl.id    = cell_id[0];
                     ctrl.burst = rem;
                     slot       = count_ff - CW'(1);
                     qleft_in   = quantum;
                  end else begin
                     ctrl.load  = 1'b1;
                     ctrl.id    = cell_id[0];
                     ctrl.burst = rem;
                     qleft_in   = ql;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign count_ext    = {4'd0, count_in};
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         qleft_ff     <= QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         qleft_ff     <= qleft_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ran_valid_ff     <= ran_valid;
         ran_id_ff        <= ran_valid ? cell_id[0] : 8'd0;
         ran_remaining_ff <= ran_valid ? rem : 8'd0;
         finished_ff      <= finished;
         rotated_ff       <= rotated;
         idle_ff          <= idle;
         add_rejected_ff  <= add_rejected;
         queue_count_ff   <= count_ext[3:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ran_valid     = ran_valid_ff;
   assign rsp_ran_id        = ran_id_ff;
   assign rsp_ran_remaining = ran_remaining_ff;
   assign rsp_finished      = finished_ff;
   assign rsp_rotated       = rotated_ff;
   assign rsp_idle          = idle_ff;
   assign rsp_add_rejected  = add_rejected_ff;
   assign rsp_queue_count   = queue_count_ff;

endmodule

`default_nettype wire

@@ rtl/rrqs_cell.sv @@
`default_nettype none

module rrqs_cell (
   input  wire                  clock,
   input  wire rrqs_pkg::cell_ctrl_type ctrl,
   input  wire                  sel,
   input  wire  [7:0]           nb_id,
   input  wire  [7:0]           nb_burst,
   output logic [7:0]           id,
   output logic [7:0]           burst
);
   import rrqs_pkg::*;

   logic [7:0] id_ff;
   logic [7:0] id_in;
   logic [7:0] burst_ff;
   logic [7:0] burst_in;

   always_comb begin
      id_in    = id_ff;
      burst_in = burst_ff;
      if (ctrl.load && sel) begin
         id_in    = ctrl.id;
         burst_in = ctrl.burst;
      end else if (ctrl.shift) begin
         id_in    = nb_id;
         burst_in = nb_burst;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      burst_ff <= burst_in;
   end

   assign id    = id_ff;
   assign burst = burst_ff;

endmodule

`default_nettype wire

@@ rtl/rrqs_csr.sv @@
`default_nettype none

module rrqs_csr (
   input  wire         clock,
   input  wire         reset,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [2:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  quantum
);
   import rrqs_pkg::*;

   logic [7:0]    quantum_ff;
   logic [7:0]    quantum_in;
   reg_index_type index;

   assign index = reg_index_type'(paddr[2]);

   always_comb begin
      quantum_in = quantum_ff;
      if (psel && penable && pwrite && (index == REG_QUANTUM)) begin
         quantum_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else begin
         quantum_ff <= quantum_in;
      end
   end

   always_comb begin
      case (index)
         REG_QUANTUM: prdata = {24'd0, quantum_ff};
         default:     prdata = 32'd0;
      endcase
   end

   assign pready  = 1'b1;
   assign quantum = quantum_ff;

endmodule

`default_nettype wire

@@ rtl/rrqs_checker.sv @@
`default_nettype none

module rrqs_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire        rsp_ran_valid,
   input wire [7:0]  rsp_ran_id,
   input wire [7:0]  rsp_ran_remaining,
   input wire        rsp_finished,
   input wire        rsp_rotated,
   input wire        rsp_idle,
   input wire        rsp_add_rejected,
   input wire [3:0]  rsp_queue_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ran_id)
         && $stable(rsp_ran_remaining) && $stable(rsp_queue_count))
      else $error("response beat changed while stalled");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_idle |-> !rsp_ran_valid && (rsp_queue_count == 4'd0)
         && !rsp_add_rejected)
      else $error("idle tick with a non-empty queue");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_ran_valid && !rsp_rotated
         && (rsp_ran_remaining == 8'd0))
      else $error("finish flagged with burst left");

   a_rotate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rotated |-> rsp_ran_valid && (rsp_ran_remaining != 8'd0)
         && (rsp_queue_count != 4'd0))
      else $error("rotation without a remaining burst");

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_ran_valid     (rsp_ran_valid),
   .rsp_ran_id        (rsp_ran_id),
   .rsp_ran_remaining (rsp_ran_remaining),
   .rsp_finished      (rsp_finished),
   .rsp_rotated       (rsp_rotated),
   .rsp_idle          (rsp_idle),
   .rsp_add_rejected  (rsp_add_rejected),
   .rsp_queue_count   (rsp_queue_count)
);

`default_nettype wire

@@ dv/round_robin_quantum_scheduler_test.sv @@
`default_nettype none

module round_robin_quantum_scheduler_test;
   import rrqs_pkg::*;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 125;
   localparam int PHASES = 10;
   localparam int DIRECTED_ROWS = 22;
   localparam logic [2:0] QUANTUM_ADDR = 3'(4 * int'(REG_QUANTUM));
   localparam logic [2:0] SPARE_ADDR = 3'(4 * int'(REG_NONE));

   typedef struct packed {
      logic       ran_valid;
      logic [7:0] ran_id;
      logic [7:0] ran_remaining;
      logic       finished;
      logic       rotated;
      logic       idle;
      logic       add_rejected;
      logic [3:0] queue_count;
   } outcome_type;

   typedef struct {
      cmd_type     command;
      logic [7:0]  id;
      logic [7:0]  burst;
      bit          typed;
      outcome_type outcome;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cmd_type     req_command = CMD_TICK;
   logic [7:0]  req_process_id = 8'h00;
   logic [7:0]  req_burst = 8'h01;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ran_valid;
   logic [7:0]  rsp_ran_id;
   logic [7:0]  rsp_ran_remaining;
   logic        rsp_finished;
   logic        rsp_rotated;
   logic        rsp_idle;
   logic        rsp_add_rejected;
   logic [3:0]  rsp_queue_count;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // scheduler state as predicted
   logic [7:0] slot_ids [QUEUE_DEPTH];
   logic [7:0] slot_bursts [QUEUE_DEPTH];
   int         head_slot = 0;
   int         queued = 0;
   logic [7:0] slice_length = QUANTUM_RESET;
   logic [7:0] slice_left = QUANTUM_RESET;

   outcome_type pending_outcomes [$];
   int       mismatches = 0;
   int       quiet_cycles = 0;
   int       burst_left = 0;
   int       stall_left = 0;
   int       stall_mode = 0;

   logic [7:0] quantum_plan [PHASES] = '{
      8'd1, 8'd255, 8'd0, 8'd2, 8'd7, 8'd3, 8'd1, 8'd4, 8'd200, 8'd5
   };

   step_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_TICK, 8'h00, 8'h00, 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0}},
      '{CMD_ADD,  8'h00, 8'h03, 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 4'd1}},
      '{CMD_ADD,  8'hFF, 8'hFF, 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 4'd2}},
      '{CMD_TICK, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_TICK, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_TICK, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_TICK, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_TICK, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_TICK, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_ADD,  8'h5A, 8'h00, 1'b0, '0},
      '{CMD_ADD,  8'hA5, 8'h02, 1'b0, '0},
      '{CMD_ADD,  8'h01, 8'h80, 1'b0, '0},
      '{CMD_ADD,  8'h80, 8'h7F, 1'b0, '0},
      '{CMD_ADD,  8'h3C, 8'h01, 1'b0, '0},
      '{CMD_ADD,  8'hC3, 8'h04, 1'b0, '0},
      '{CMD_ADD,  8'h7E, 8'h05, 1'b0, '0},
      '{CMD_ADD,  8'h99, 8'h06, 1'b1, '{1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 4'd8}},
      '{CMD_TICK, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_TICK, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_TICK, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_TICK, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_TICK, 8'h00, 8'h00, 1'b0, '0}
   };

   round_robin_quantum_scheduler #(
      .MAX_PROCS(QUEUE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_process_id(req_process_id),
      .req_burst(req_burst),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_ran_valid(rsp_ran_valid),
      .rsp_ran_id(rsp_ran_id),
      .rsp_ran_remaining(rsp_ran_remaining),
      .rsp_finished(rsp_finished),
      .rsp_rotated(rsp_rotated),
      .rsp_idle(rsp_idle),
      .rsp_add_rejected(rsp_add_rejected),
      .rsp_queue_count(rsp_queue_count),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic outcome_type schedule_step(cmd_type command, logic [7:0] id,
                                                 logic [7:0] burst);
      outcome_type o;
      int          slot;
      logic [7:0]  left;
      logic [7:0]  slice;
      o = '0;
      if (command == CMD_ADD) begin
         if (queued >= QUEUE_DEPTH) begin
            o.add_rejected = 1'b1;
         end else begin
            slot = (head_slot + queued) % QUEUE_DEPTH;
            slot_ids[slot] = id;
            slot_bursts[slot] = burst;
            if (queued == 0) slice_left = slice_length;
            queued++;
         end
      end else if (queued == 0) begin
         o.idle = 1'b1;
      end else begin
         left = slot_bursts[head_slot];
         slice = slice_left;
         if (left != 0) left--;
         if (slice != 0) slice--;
         o.ran_valid = 1'b1;
         o.ran_id = slot_ids[head_slot];
         o.ran_remaining = left;
         if (left == 0) begin
            o.finished = 1'b1;
            head_slot = (head_slot + 1) % QUEUE_DEPTH;
            queued--;
            slice_left = slice_length;
         end else if (slice == 0) begin
            slot = (head_slot + queued) % QUEUE_DEPTH;
            o.rotated = 1'b1;
            slot_ids[slot] = slot_ids[head_slot];
            slot_bursts[slot] = left;
            head_slot = (head_slot + 1) % QUEUE_DEPTH;
            slice_left = slice_length;
         end else begin
            slot_bursts[head_slot] = left;
            slice_left = slice;
         end
      end
      o.queue_count = 4'(queued);
      return o;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         mismatches++;
      end
   endtask

   // idle the sender between bursts of beats
   task automatic pace();
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   task automatic send_beat(cmd_type command, logic [7:0] id, logic [7:0] burst,
                            bit typed, outcome_type typed_outcome);
      outcome_type predicted;
      pace();
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= command;
      req_process_id <= id;
      req_burst <= burst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = schedule_step(command, id, burst);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_access(bit write, logic [2:0] addr, logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= addr;
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // receiver stall pattern: segments of no stall, light, medium and heavy stall
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(5, 40);
      end else begin
         stall_left--;
      end
      rsp_stall <= (stall_mode != 0) && ($urandom_range(1, 4) <= stall_mode);
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("response beat with nothing expected");
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("ran_valid", 32'(want.ran_valid), 32'(rsp_ran_valid));
            check_field("ran_id", 32'(want.ran_id), 32'(rsp_ran_id));
            check_field("ran_remaining", 32'(want.ran_remaining), 32'(rsp_ran_remaining));
            check_field("finished", 32'(want.finished), 32'(rsp_finished));
            check_field("rotated", 32'(want.rotated), 32'(rsp_rotated));
            check_field("idle", 32'(want.idle), 32'(rsp_idle));
            check_field("add_rejected", 32'(want.add_rejected), 32'(rsp_add_rejected));
            check_field("queue_count", 32'(want.queue_count), 32'(rsp_queue_count));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [31:0] readback;
      logic [7:0]  quantum;
      logic [7:0]  burst;
      cmd_type     command;
      int          add_percent;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_access(1'b0, QUANTUM_ADDR, 32'd0, readback);
      check_field("quantum", {24'd0, QUANTUM_RESET}, readback);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_beat(directed_rows[r].command, directed_rows[r].id, directed_rows[r].burst,
                   directed_rows[r].typed, directed_rows[r].outcome);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         // spare address: write must leave the quantum alone
         csr_access(1'b1, SPARE_ADDR, $urandom, readback);
         quantum = quantum_plan[p];
         csr_access(1'b1, QUANTUM_ADDR, {24'($urandom), quantum}, readback);
         slice_length = quantum;
         csr_access(1'b0, QUANTUM_ADDR, 32'd0, readback);
         check_field("quantum", {24'd0, quantum}, readback);
         add_percent = $urandom_range(25, 75);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            command = ($urandom_range(0, 99) < add_percent) ? CMD_ADD : CMD_TICK;
            burst = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(1, 6));
            send_beat(command, 8'($urandom), burst, 1'b0, '0);
         end
      end

      drain();
      repeat (5) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
